FILE: rtl/lfss_pkg.sv
// Shared types, constants and codes of the line follower steering step unit.
package lfss_pkg;

   localparam int CFG_W = 12;
   localparam int SPEED_W = 8;
   localparam int EDGE_W = 2;
   localparam int CLS_W = 2;
   localparam int AGE_W = 13;
   localparam int HUND_W = 7;
   localparam int CSR_ADDR_W = 3;
   localparam int DEFAULT_SAMPLE_WIDTH = 12;
   localparam int RSP_W = 24;

   // Edge age: clear the latch once this old, never count past the cap.
   localparam logic [AGE_W-1:0] AGE_CLEAR = AGE_W'(350);
   localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(5000);

   // Hundredths that pass the speed through unchanged.
   localparam logic [HUND_W-1:0] HUND_FULL = HUND_W'(100);

   // x / 100 == (x * 5243) >> 19 for every x below 16384.
   localparam int PROD_W = SPEED_W + HUND_W;
   localparam int RECIP_W = 13;
   localparam logic [RECIP_W-1:0] RECIP_MUL = RECIP_W'(5243);
   localparam int RECIP_SHIFT = 19;

   localparam logic [CFG_W-1:0] RST_WHITE = CFG_W'(0);
   localparam logic [CFG_W-1:0] RST_SPAN = CFG_W'(1000);
   localparam logic [CFG_W-1:0] RST_THRESHOLD = CFG_W'(2048);

   // Register indexes of the write port.
   localparam logic [CSR_ADDR_W-1:0] CSR_WHITE_LEFT = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_WHITE_CENTER = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_WHITE_RIGHT = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPAN_LEFT = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPAN_CENTER = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPAN_RIGHT = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_THRESH_LEFT = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] CSR_THRESH_RIGHT = 3'd7;

   // Latched outer edge.
   localparam logic [EDGE_W-1:0] EDGE_NONE = 2'd0;
   localparam logic [EDGE_W-1:0] EDGE_LEFT = 2'd1;
   localparam logic [EDGE_W-1:0] EDGE_RIGHT = 2'd2;

   // Steering class.
   localparam logic [CLS_W-1:0] STEER_AHEAD = 2'd0;
   localparam logic [CLS_W-1:0] STEER_LEFT = 2'd1;
   localparam logic [CLS_W-1:0] STEER_RIGHT = 2'd2;
   localparam logic [CLS_W-1:0] STEER_SHARP = 2'd3;

   // One wheel command: speed or its negation, times hundredths.
   typedef struct packed {
      logic neg;
      logic [HUND_W-1:0] hund;
   } lfss_side_type;

   typedef struct packed {
      logic drive;
      lfss_side_type left;
      lfss_side_type right;
   } lfss_decision_type;

   typedef struct packed {
      logic [CLS_W-1:0] steer_cls;
      logic [EDGE_W-1:0] edge_latch;
      logic [AGE_W-1:0] edge_age;
   } lfss_track_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_DIVIDE,
      FSM_MERGE,
      FSM_SCALE,
      FSM_OUTPUT
   } lfss_fsm_type;

   // Magnitude width of sample minus white level.
   function automatic int lfss_mag_width(int sample_width);
      return (sample_width > CFG_W) ? sample_width : CFG_W;
   endfunction

endpackage

FILE: rtl/lfss_pct_lane.sv
// One calibration lane: (raw - white) * 100 / span with a bit-serial divider.
module lfss_pct_lane #(
   parameter int SAMPLE_WIDTH = lfss_pkg::DEFAULT_SAMPLE_WIDTH
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [SAMPLE_WIDTH-1:0] raw,
   input  logic [lfss_pkg::CFG_W-1:0] white,
   input  logic [lfss_pkg::CFG_W-1:0] span,
   output logic signed [lfss_pkg::lfss_mag_width(SAMPLE_WIDTH)+7:0] pct,
   output logic pct_valid
);
   import lfss_pkg::*;

   localparam int MW = lfss_mag_width(SAMPLE_WIDTH);
   localparam int NW = MW + 7;
   localparam int CW = (NW > 1) ? $clog2(NW) : 1;

   logic signed [MW:0] diff;
   logic neg;
   logic [MW-1:0] abs_diff;
   logic [NW-1:0] scaled;
   logic [CFG_W:0] trial;
   logic fit;
   logic [CFG_W-1:0] rem_in;
   logic last;

   logic busy_ff, valid_ff, neg_ff;
   logic [NW-1:0] quo_ff;
   logic [CFG_W-1:0] rem_ff, div_ff;
   logic [CW-1:0] cnt_ff;

   assign diff = $signed({1'b0, MW'(raw)}) - $signed({1'b0, MW'(white)});
   assign neg = diff[MW];
   assign abs_diff = neg ? MW'(-diff) : MW'(diff);
   assign scaled = NW'(abs_diff) * NW'(100);

   // restoring step: one quotient bit a cycle
   assign trial = {rem_ff, quo_ff[NW-1]};
   assign fit = trial >= {1'b0, div_ff};
   assign rem_in = fit ? CFG_W'(trial - {1'b0, div_ff}) : trial[CFG_W-1:0];
   assign last = cnt_ff == CW'(NW - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         valid_ff <= 1'b0;
      end else if (busy_ff && last) begin
         busy_ff <= 1'b0;
         valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= scaled;
         rem_ff <= '0;
         div_ff <= (span == '0) ? CFG_W'(1) : span;
         neg_ff <= neg;
         cnt_ff <= '0;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[NW-2:0], fit};
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   assign pct = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
   assign pct_valid = valid_ff;

endmodule

FILE: rtl/lfss_merge.sv
// Merge of the three lane percentages into drive choice and edge tracking.
module lfss_merge #(
   parameter int PW = 20
) (
   input  logic signed [PW-1:0] pct_left,
   input  logic signed [PW-1:0] pct_mid,
   input  logic signed [PW-1:0] pct_right,
   input  logic right_first,
   input  logic hit_left,
   input  logic hit_right,
   input  lfss_pkg::lfss_track_type track_cur,
   output lfss_pkg::lfss_track_type track_nxt,
   output lfss_pkg::lfss_decision_type decision
);
   import lfss_pkg::*;

   localparam int DW = PW + 1;

   logic signed [DW-1:0] diff_lr, diff_rl;
   logic [HUND_W-1:0] ladder_l, ladder_r;
   logic [HUND_W-1:0] side_h_l, side_h_r;
   logic found_l, found_r, sharp_l, sharp_r;

   function automatic logic [HUND_W-1:0] bend_hund(logic signed [DW-1:0] d);
      if (d < DW'(20)) return HUND_W'(95);
      else if (d < DW'(40)) return HUND_W'(90);
      else if (d < DW'(60)) return HUND_W'(85);
      else return HUND_W'(80);
   endfunction

   // Neither ladder hit: reduce, stop or reverse the inner wheel by side depth.
   function automatic lfss_side_type side_fallback(logic signed [PW-1:0] p);
      lfss_side_type s;
      s.neg = 1'b0;
      if (p > PW'(70)) s.hund = HUND_W'(10);
      else if (p > PW'(60)) s.hund = HUND_W'(5);
      else if (p > PW'(50)) s.hund = HUND_W'(0);
      else if (p > PW'(40)) begin
         s.neg = 1'b1;
         s.hund = HUND_W'(5);
      end else begin
         s.neg = 1'b1;
         s.hund = HUND_W'(10);
      end
      return s;
   endfunction

   assign diff_lr = DW'(pct_left) - DW'(pct_right);
   assign diff_rl = DW'(pct_right) - DW'(pct_left);

   // Center ladders: the highest step below the center value wins.
   always_comb begin
      ladder_l = HUND_W'(40);
      ladder_r = HUND_W'(40);
      for (int k = 0; k < 9; k++) begin
         if (pct_mid > PW'(35 + 5 * k)) ladder_l = HUND_W'(45 + 5 * k);
         if (k > 0 && pct_mid > PW'(35 + 5 * k)) ladder_r = HUND_W'(45 + 5 * k);
      end
   end

   // Side ladders from 60 down to 10 (left) or 5 (right).
   always_comb begin
      found_l = 1'b0;
      found_r = 1'b0;
      sharp_l = 1'b0;
      sharp_r = 1'b0;
      side_h_l = '0;
      side_h_r = '0;
      for (int k = 1; k <= 12; k++) begin
         if (pct_mid > PW'(5 * k)) begin
            if (k >= 2) begin
               found_l = 1'b1;
               side_h_l = HUND_W'(5 * k + 10);
               sharp_l = (k >= 6);
            end
            found_r = 1'b1;
            side_h_r = HUND_W'(5 * k + 10);
            sharp_r = (k >= 6);
         end
      end
   end

   always_comb begin
      logic [AGE_W-1:0] age_v;
      logic [EDGE_W-1:0] latch_v;
      logic [CLS_W-1:0] cls_v;
      logic tick, on_mid, lean_l, lean_r;
      lfss_side_type full, side_v;

      full.neg = 1'b0;
      full.hund = HUND_FULL;
      side_v = '0;
      decision = '0;
      tick = 1'b0;

      age_v = (hit_left || hit_right) ? '0 : track_cur.edge_age;
      if (right_first) begin
         latch_v = hit_left ? EDGE_LEFT : (hit_right ? EDGE_RIGHT : track_cur.edge_latch);
      end else begin
         latch_v = hit_right ? EDGE_RIGHT : (hit_left ? EDGE_LEFT : track_cur.edge_latch);
      end
      if (age_v >= AGE_CLEAR) begin
         latch_v = EDGE_NONE;
         age_v = '0;
      end
      cls_v = track_cur.steer_cls;

      on_mid = (pct_mid > PW'(80)) ||
               (pct_mid >= pct_left && pct_mid >= pct_right && pct_mid > PW'(20));
      lean_l = pct_left > pct_right && pct_left > PW'(25);
      lean_r = pct_right > pct_left && pct_right > PW'(25);

      if (on_mid) begin
         tick = 1'b1;
         decision.drive = 1'b1;
         if (pct_left > pct_right && pct_left > PW'(5)) begin
            decision.left.hund = (pct_mid > PW'(80)) ? bend_hund(diff_lr) : ladder_l;
            decision.right = full;
            cls_v = STEER_SHARP;
         end else if (pct_right > pct_left && pct_right > PW'(5)) begin
            decision.left = full;
            decision.right.hund = (pct_mid > PW'(80)) ? bend_hund(diff_rl) : ladder_r;
            cls_v = STEER_SHARP;
         end else begin
            decision.left = full;
            decision.right = full;
            cls_v = STEER_AHEAD;
         end
      end else if (lean_l || lean_r) begin
         tick = 1'b1;
         decision.drive = 1'b1;
         if (lean_l) begin
            if (found_l) begin
               side_v.hund = side_h_l;
               cls_v = sharp_l ? STEER_SHARP : STEER_LEFT;
            end else begin
               side_v = side_fallback(pct_left);
               cls_v = STEER_LEFT;
            end
            decision.left = side_v;
            decision.right = full;
         end else begin
            if (found_r) begin
               side_v.hund = side_h_r;
               cls_v = sharp_r ? STEER_SHARP : STEER_RIGHT;
            end else begin
               side_v = side_fallback(pct_right);
               cls_v = STEER_RIGHT;
            end
            decision.left = full;
            decision.right = side_v;
         end
      end else begin
         // line lost: spin back toward the remembered edge, the class or an outer hit
         side_v.neg = 1'b1;
         if (latch_v == EDGE_LEFT && pct_left < PW'(5)) begin
            side_v.hund = HUND_W'(30);
            decision = '{drive: 1'b1, left: side_v, right: full};
         end else if (latch_v == EDGE_RIGHT && pct_right < PW'(5)) begin
            side_v.hund = HUND_W'(30);
            decision = '{drive: 1'b1, left: full, right: side_v};
         end else if (track_cur.steer_cls == STEER_LEFT) begin
            side_v.hund = (pct_left > PW'(10)) ? HUND_W'(15) : HUND_W'(20);
            if (pct_left > PW'(5)) decision = '{drive: 1'b1, left: side_v, right: full};
         end else if (track_cur.steer_cls == STEER_RIGHT) begin
            side_v.hund = (pct_right > PW'(10)) ? HUND_W'(15) : HUND_W'(20);
            if (pct_right > PW'(5)) decision = '{drive: 1'b1, left: full, right: side_v};
         end else begin
            side_v.hund = HUND_W'(30);
            if (hit_left) decision = '{drive: 1'b1, left: side_v, right: full};
            else if (hit_right) decision = '{drive: 1'b1, left: full, right: side_v};
         end
      end

      if (tick && latch_v != EDGE_NONE && age_v < AGE_MAX) begin
         age_v = age_v + 1'b1;
      end

      track_nxt.steer_cls = cls_v;
      track_nxt.edge_latch = latch_v;
      track_nxt.edge_age = age_v;
   end

endmodule

FILE: rtl/lfss_drive_scale.sv
// Wheel command scaler: (+/-speed * hundredths) / 100, truncated toward zero.
module lfss_drive_scale (
   input  logic clock,
   input  logic load,
   input  logic signed [lfss_pkg::SPEED_W-1:0] speed,
   input  lfss_pkg::lfss_side_type side,
   output logic [lfss_pkg::SPEED_W-1:0] drive
);
   import lfss_pkg::*;

   logic signed [SPEED_W:0] vel;
   logic [SPEED_W-1:0] mag;
   logic [PROD_W+RECIP_W-1:0] recip;
   logic [SPEED_W-1:0] quo;

   logic [PROD_W-1:0] prod_ff;
   logic sign_ff;

   assign vel = side.neg ? -(SPEED_W+1)'(speed) : (SPEED_W+1)'(speed);
   assign mag = vel[SPEED_W] ? SPEED_W'(-vel) : SPEED_W'(vel);

   // hold magnitude product for the reciprocal multiply
   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= PROD_W'(mag) * PROD_W'(side.hund);
         sign_ff <= vel[SPEED_W];
      end
   end

   assign recip = (PROD_W + RECIP_W)'(prod_ff) * (PROD_W + RECIP_W)'(RECIP_MUL);
   assign quo = recip[RECIP_SHIFT +: SPEED_W];
   assign drive = sign_ff ? -quo : quo;

endmodule

FILE: rtl/line_follower_steering_step_unit.sv
// Top level of the line follower steering step unit.
// One req beat is one control tick: five raw reflectance samples, a signed speed
// in percent and an edge priority flag. Three lanes turn the inner samples into
// calibrated percentages, each with its own bit-serial divider that yields one
// quotient bit a cycle; a merge stage then picks the wheel commands, updates the
// steering class and the outer edge latch with its age counter, and a scaler
// forms speed times hundredths over 100. Each rsp beat carries the drive flag,
// both wheel commands and the edge latch after the tick. The next tick is
// accepted after the result is registered. The unit works on one tick at a
// time; a result that waits for rsp_tready holds the next tick at its final
// stage. Calibration registers are written through csr_* and take effect for
// ticks accepted after the write.
module line_follower_steering_step_unit #(
   parameter int SAMPLE_WIDTH = lfss_pkg::DEFAULT_SAMPLE_WIDTH
) (
   input  logic clock,
   input  logic reset,

   input  logic req_tvalid,
   output logic req_tready,
   // speed[7:0], right_first[8], then sample_far_left, sample_left, sample_mid,
   // sample_right, sample_far_right at SAMPLE_WIDTH bits each, zero padded
   input  logic [((lfss_pkg::SPEED_W + 1 + 5 * SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,

   output logic rsp_tvalid,
   input  logic rsp_tready,
   // drive_update[0], left_drive[8:1], right_drive[16:9], edge_seen[18:17], zero padded
   output logic [lfss_pkg::RSP_W-1:0] rsp_tdata,

   input  logic csr_we,
   input  logic [lfss_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [lfss_pkg::CFG_W-1:0] csr_wdata
);
   import lfss_pkg::*;

   localparam int SW = SAMPLE_WIDTH;
   localparam int MW = lfss_mag_width(SW);
   localparam int PW = MW + 8;
   localparam int SMP_LO = SPEED_W + 1;

   // Calibration registers.
   logic [CFG_W-1:0] white_left_ff, white_center_ff, white_right_ff;
   logic [CFG_W-1:0] span_left_ff, span_center_ff, span_right_ff;
   logic [CFG_W-1:0] thresh_left_ff, thresh_right_ff;

   // Tick fields held while the lanes run.
   logic signed [SPEED_W-1:0] speed_ff;
   logic right_first_ff, hit_left_ff, hit_right_ff;

   logic [SW-1:0] far_left, far_right;
   logic hit_left, hit_right;

   lfss_fsm_type fsm_ff, fsm_in;
   logic lane_start, merge_load, scale_load, out_load;

   logic signed [PW-1:0] pct_left, pct_mid, pct_right;
   logic [2:0] lane_valid;

   lfss_track_type track_ff, track_in;
   lfss_decision_type dec_ff, dec_in;

   logic [SPEED_W-1:0] left_drive, right_drive;

   logic rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   // Register writes: decode the index, drop anything else.
   always_ff @(posedge clock) begin
      if (reset) begin
         white_left_ff <= RST_WHITE;
         white_center_ff <= RST_WHITE;
         white_right_ff <= RST_WHITE;
         span_left_ff <= RST_SPAN;
         span_center_ff <= RST_SPAN;
         span_right_ff <= RST_SPAN;
         thresh_left_ff <= RST_THRESHOLD;
         thresh_right_ff <= RST_THRESHOLD;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_WHITE_LEFT: white_left_ff <= csr_wdata;
            CSR_WHITE_CENTER: white_center_ff <= csr_wdata;
            CSR_WHITE_RIGHT: white_right_ff <= csr_wdata;
            CSR_SPAN_LEFT: span_left_ff <= csr_wdata;
            CSR_SPAN_CENTER: span_center_ff <= csr_wdata;
            CSR_SPAN_RIGHT: span_right_ff <= csr_wdata;
            CSR_THRESH_LEFT: thresh_left_ff <= csr_wdata;
            CSR_THRESH_RIGHT: thresh_right_ff <= csr_wdata;
         endcase
      end
   end

   // Outer edge compares need no divider: resolve them on the accepted beat.
   assign far_left = req_tdata[SMP_LO +: SW];
   assign far_right = req_tdata[SMP_LO + 4 * SW +: SW];
   assign hit_left = MW'(far_left) > MW'(thresh_left_ff);
   assign hit_right = MW'(far_right) > MW'(thresh_right_ff);

   always_ff @(posedge clock) begin
      if (lane_start) begin
         speed_ff <= $signed(req_tdata[SPEED_W-1:0]);
         right_first_ff <= req_tdata[SPEED_W];
         hit_left_ff <= hit_left;
         hit_right_ff <= hit_right;
      end
   end

   // Three calibration lanes, all the same length.
   lfss_pct_lane #(.SAMPLE_WIDTH(SW)) u_lane_left (
      .clock(clock), .reset(reset), .start(lane_start),
      .raw(req_tdata[SMP_LO + SW +: SW]), .white(white_left_ff), .span(span_left_ff),
      .pct(pct_left), .pct_valid(lane_valid[0])
   );

   lfss_pct_lane #(.SAMPLE_WIDTH(SW)) u_lane_mid (
      .clock(clock), .reset(reset), .start(lane_start),
      .raw(req_tdata[SMP_LO + 2 * SW +: SW]), .white(white_center_ff), .span(span_center_ff),
      .pct(pct_mid), .pct_valid(lane_valid[1])
   );

   lfss_pct_lane #(.SAMPLE_WIDTH(SW)) u_lane_right (
      .clock(clock), .reset(reset), .start(lane_start),
      .raw(req_tdata[SMP_LO + 3 * SW +: SW]), .white(white_right_ff), .span(span_right_ff),
      .pct(pct_right), .pct_valid(lane_valid[2])
   );

   lfss_merge #(.PW(PW)) u_merge (
      .pct_left(pct_left), .pct_mid(pct_mid), .pct_right(pct_right),
      .right_first(right_first_ff), .hit_left(hit_left_ff), .hit_right(hit_right_ff),
      .track_cur(track_ff), .track_nxt(track_in), .decision(dec_in)
   );

   // Steering class and edge tracking advance once per tick, at merge.
   always_ff @(posedge clock) begin
      if (reset) begin
         track_ff <= '0;
      end else if (merge_load) begin
         track_ff <= track_in;
      end
   end

   always_ff @(posedge clock) begin
      if (merge_load) begin
         dec_ff <= dec_in;
      end
   end

   lfss_drive_scale u_scale_left (
      .clock(clock), .load(scale_load), .speed(speed_ff), .side(dec_ff.left),
      .drive(left_drive)
   );

   lfss_drive_scale u_scale_right (
      .clock(clock), .load(scale_load), .speed(speed_ff), .side(dec_ff.right),
      .drive(right_drive)
   );

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff <= FSM_IDLE;
      end else begin
         fsm_ff <= fsm_in;
      end
   end

   always_comb begin
      fsm_in = fsm_ff;
      req_tready = 1'b0;
      lane_start = 1'b0;
      merge_load = 1'b0;
      scale_load = 1'b0;
      out_load = 1'b0;
      unique case (fsm_ff)
         FSM_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               lane_start = 1'b1;
               fsm_in = FSM_DIVIDE;
            end
         end
         FSM_DIVIDE: begin
            if (&lane_valid) fsm_in = FSM_MERGE;
         end
         FSM_MERGE: begin
            merge_load = 1'b1;
            fsm_in = FSM_SCALE;
         end
         FSM_SCALE: begin
            scale_load = 1'b1;
            fsm_in = FSM_OUTPUT;
         end
         FSM_OUTPUT: begin
            // hold until the output register is free or drains this cycle
            if (!rsp_tvalid_ff || rsp_tready) begin
               out_load = 1'b1;
               fsm_in = FSM_IDLE;
            end
         end
         default: fsm_in = FSM_IDLE;
      endcase
   end

   // Output register.
   assign rsp_tdata_in = RSP_W'({track_ff.edge_latch, right_drive, left_drive, dec_ff.drive});
   assign rsp_tvalid_in = out_load || (rsp_tvalid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata = rsp_tdata_ff;

`ifndef SYNTHESIS
   // With no edge latched the age counter must sit at zero.
   a_age_idle: assert property (@(posedge clock) disable iff (reset)
      track_ff.edge_latch == EDGE_NONE |-> track_ff.edge_age == '0)
      else $error("edge age running without a latched edge");

   // Merge only sees finished lane results.
   a_merge_lanes: assert property (@(posedge clock) disable iff (reset)
      fsm_ff == FSM_MERGE |-> &lane_valid)
      else $error("merge before all lanes finished");

   // A beat without drive carries zero wheel commands.
   a_no_drive_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[16:1] == '0)
      else $error("wheel command on a beat without drive");

   // Tracking state moves only at merge.
   a_track_hold: assert property (@(posedge clock) disable iff (reset)
      fsm_ff != FSM_MERGE |=> $stable(track_ff))
      else $error("tracking state changed outside merge");

   // An accepted beat starts the lanes.
   a_accept_divide: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> fsm_ff == FSM_DIVIDE && lane_valid == '0)
      else $error("accepted beat did not start the lanes");
`endif

endmodule
